// ===== hdl/xcfr_pkg.sv =====
// Package for the XOR-checked frame receiver.
// Holds frame phase and event codes, register map and shared structs.
// No dependencies.
package xcfr_pkg;

  // APB register map
  localparam int unsigned ApbAddrW = 4;
  localparam int unsigned ApbDataW = 32;

  typedef enum logic [1:0] {
    REG_START_MARKER = 2'd0,
    REG_MAX_LEN      = 2'd1,
    REG_GAP_TIMEOUT  = 2'd2
  } reg_idx_e;

  // Register reset values
  localparam logic [7:0]  StartMarkerRst = 8'hAA;
  localparam logic [15:0] MaxLenRst      = 16'd256;
  localparam logic [15:0] GapTimeoutRst  = 16'd100;

  localparam logic [15:0] IdleSat = 16'hFFFF;

  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_ID     = 3'd1,
    PH_LEN_HI = 3'd2,
    PH_LEN_LO = 3'd3,
    PH_DATA   = 3'd4,
    PH_CHECK  = 3'd5
  } phase_e;

  typedef enum logic [2:0] {
    EV_DATA     = 3'd0,
    EV_GOOD     = 3'd1,
    EV_BAD_SUM  = 3'd2,
    EV_TOO_LONG = 3'd3,
    EV_TIMEOUT  = 3'd4
  } event_e;

  typedef enum logic {
    REQ_BYTE = 1'b0,
    REQ_TICK = 1'b1
  } req_e;

  typedef struct packed {
    logic [7:0]  start_marker;
    logic [15:0] max_payload_len;
    logic [15:0] gap_timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [7:0]  frame_id;
    logic [15:0] frame_len;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
  } result_t;

endpackage

// ===== hdl/xcfr_in_if.sv =====
// Input channel of the frame receiver: one byte or one tick per transaction.
// Valid/ready handshake. No dependencies.
interface xcfr_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] rx_byte;

  modport source (output valid, output req_type, output rx_byte, input ready);
  modport sink   (input valid, input req_type, input rx_byte, output ready);
endinterface

// ===== hdl/xcfr_out_if.sv =====
// Output channel of the frame receiver: one event per transaction.
// Valid/ready handshake. No dependencies.
interface xcfr_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_kind;
  logic [7:0]  frame_id;
  logic [15:0] frame_len;
  logic [7:0]  payload_byte;
  logic [15:0] payload_index;

  modport source (output valid, output event_kind, output frame_id, output frame_len,
                  output payload_byte, output payload_index, input ready);
  modport sink   (input valid, input event_kind, input frame_id, input frame_len,
                  input payload_byte, input payload_index, output ready);
endinterface

// ===== hdl/xor_checked_frame_receiver.sv =====
// Deframer for start byte / id / 16-bit length / payload / XOR checksum.
// Path: input transaction to result through the input register, then the
// result register. Throughput: one byte or tick per cycle while the output
// is drained; the phase registers update on every taken item.
// Reset: asynchronous, active low; hunting for the start byte, registers at
// start marker 0xAA, max length 256, gap timeout 100 ticks.
module xor_checked_frame_receiver (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  xcfr_in_if.sink                       in_if,
  xcfr_out_if.source                    out_if,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [xcfr_pkg::ApbAddrW-1:0] paddr,
  input  logic [xcfr_pkg::ApbDataW-1:0] pwdata,
  output logic [xcfr_pkg::ApbDataW-1:0] prdata,
  output logic                          pready
);
  import xcfr_pkg::*;

  cfg_t  cfg;
  logic  s0_valid;
  item_t s0_item;
  logic  s0_take;

  xcfr_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  xcfr_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (in_if),
    .take_i  (s0_take),
    .valid_o (s0_valid),
    .item_o  (s0_item)
  );

  xcfr_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (s0_valid),
    .item_i  (s0_item),
    .take_o  (s0_take),
    .out_if  (out_if)
  );
endmodule

// ===== hdl/xcfr_regs.sv =====
// APB configuration registers of the frame receiver.
// Depends on xcfr_pkg.
module xcfr_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [xcfr_pkg::ApbAddrW-1:0] paddr,
  input  logic [xcfr_pkg::ApbDataW-1:0] pwdata,
  output logic [xcfr_pkg::ApbDataW-1:0] prdata,
  output logic                          pready,
  output xcfr_pkg::cfg_t                cfg_o
);
  import xcfr_pkg::*;

  cfg_t     cfg_q;
  logic     wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_e'(paddr[3:2]);

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_marker      <= StartMarkerRst;
      cfg_q.max_payload_len   <= MaxLenRst;
      cfg_q.gap_timeout_ticks <= GapTimeoutRst;
    end else if (wr_en) begin
      case (idx)
        REG_START_MARKER: cfg_q.start_marker      <= pwdata[7:0];
        REG_MAX_LEN:      cfg_q.max_payload_len   <= pwdata[15:0];
        REG_GAP_TIMEOUT:  cfg_q.gap_timeout_ticks <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (idx)
      REG_START_MARKER: prdata = {24'd0, cfg_q.start_marker};
      REG_MAX_LEN:      prdata = {16'd0, cfg_q.max_payload_len};
      REG_GAP_TIMEOUT:  prdata = {16'd0, cfg_q.gap_timeout_ticks};
      default:          prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;
endmodule

// ===== hdl/xcfr_in_stage.sv =====
// Input register of the frame receiver: holds one accepted transaction.
// Depends on xcfr_pkg and xcfr_in_if.
module xcfr_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  xcfr_in_if.sink         in_if,
  input  logic            take_i,
  output logic            valid_o,
  output xcfr_pkg::item_t item_o
);
  import xcfr_pkg::*;

  logic  valid_q;
  item_t item_q;
  logic  accept;

  // refill in the same cycle the held item moves on
  assign in_if.ready = ~valid_q | take_i;
  assign accept      = in_if.valid & in_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= accept | (valid_q & ~take_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.req_type <= in_if.req_type;
      item_q.rx_byte  <= in_if.rx_byte;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;
endmodule

// ===== hdl/xcfr_core.sv =====
// Frame state machine with XOR checksum and gap timer, plus result register.
// Depends on xcfr_pkg and xcfr_out_if.
module xcfr_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  xcfr_pkg::cfg_t  cfg_i,
  input  logic            valid_i,
  input  xcfr_pkg::item_t item_i,
  output logic            take_o,
  xcfr_out_if.source      out_if
);
  import xcfr_pkg::*;

  phase_e      phase_q, phase_d;
  logic [7:0]  id_q, id_d;
  logic [15:0] len_q, len_d;
  logic [15:0] seen_q, seen_d;
  logic [7:0]  xor_q, xor_d;
  logic [15:0] idle_q, idle_d;

  logic        res_valid;
  result_t     res;
  logic        out_valid_q;
  result_t     out_q;

  logic [15:0] idle_inc;
  logic [15:0] len_full;
  logic [15:0] seen_inc;
  logic [7:0]  b;

  // item moves on whenever the result slot is free or being drained
  assign take_o = valid_i & (~out_valid_q | out_if.ready);

  assign b        = item_i.rx_byte;
  assign idle_inc = (idle_q == IdleSat) ? idle_q : idle_q + 16'd1;
  assign len_full = {len_q[15:8], b};
  assign seen_inc = seen_q + 16'd1;

  // next state and result
  always_comb begin
    phase_d   = phase_q;
    id_d      = id_q;
    len_d     = len_q;
    seen_d    = seen_q;
    xor_d     = xor_q;
    idle_d    = idle_q;
    res_valid = 1'b0;
    res.event_kind    = EV_DATA;
    res.frame_id      = id_q;
    res.frame_len     = len_q;
    res.payload_byte  = 8'd0;
    res.payload_index = 16'd0;

    if (item_i.req_type == REQ_TICK) begin
      // ticks only count inside a frame
      if (phase_q != PH_HUNT) begin
        idle_d = idle_inc;
        if (idle_inc >= cfg_i.gap_timeout_ticks) begin
          res_valid      = 1'b1;
          res.event_kind = EV_TIMEOUT;
          res.frame_len  = (phase_q == PH_DATA || phase_q == PH_CHECK) ? len_q : 16'd0;
          phase_d        = PH_HUNT;
          idle_d         = 16'd0;
        end
      end
    end else begin
      idle_d = 16'd0;
      case (phase_q)
        PH_ID: begin
          id_d    = b;
          xor_d   = xor_q ^ b;
          phase_d = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          len_d   = {b, 8'd0};
          xor_d   = xor_q ^ b;
          phase_d = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          len_d = len_full;
          xor_d = xor_q ^ b;
          if (len_full > cfg_i.max_payload_len) begin
            res_valid      = 1'b1;
            res.event_kind = EV_TOO_LONG;
            res.frame_len  = len_full;
            phase_d        = PH_HUNT;
          end else begin
            phase_d = (len_full == 16'd0) ? PH_CHECK : PH_DATA;
          end
        end
        PH_DATA: begin
          res_valid         = 1'b1;
          res.payload_byte  = b;
          res.payload_index = seen_q;
          xor_d             = xor_q ^ b;
          seen_d            = seen_inc;
          if (seen_inc >= len_q) begin
            phase_d = PH_CHECK;
          end
        end
        PH_CHECK: begin
          res_valid      = 1'b1;
          res.event_kind = (b == xor_q) ? EV_GOOD : EV_BAD_SUM;
          phase_d        = PH_HUNT;
        end
        default: begin
          // hunting: only the start marker opens a frame
          if (b == cfg_i.start_marker) begin
            phase_d = PH_ID;
            xor_d   = b;
            id_d    = 8'd0;
            len_d   = 16'd0;
            seen_d  = 16'd0;
          end else begin
            phase_d = PH_HUNT;
          end
        end
      endcase
    end
  end

  // frame state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      id_q    <= 8'd0;
      len_q   <= 16'd0;
      seen_q  <= 16'd0;
      xor_q   <= 8'd0;
      idle_q  <= 16'd0;
    end else if (take_o) begin
      phase_q <= phase_d;
      id_q    <= id_d;
      len_q   <= len_d;
      seen_q  <= seen_d;
      xor_q   <= xor_d;
      idle_q  <= idle_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (~out_valid_q | out_if.ready) begin
      out_valid_q <= take_o & res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o & res_valid) begin
      out_q <= res;
    end
  end

  assign out_if.valid         = out_valid_q;
  assign out_if.event_kind    = out_q.event_kind;
  assign out_if.frame_id      = out_q.frame_id;
  assign out_if.frame_len     = out_q.frame_len;
  assign out_if.payload_byte  = out_q.payload_byte;
  assign out_if.payload_index = out_q.payload_index;
endmodule

// ===== tb/xor_checked_frame_receiver_tb.sv =====
`timescale 1ns / 1ps
// Testbench for xor_checked_frame_receiver: directed and random byte/tick streams,
// checked event by event against a built-in deframer predictor.
// Depends on xcfr_pkg, xcfr_in_if, xcfr_out_if and the receiver RTL.
module xor_checked_frame_receiver_tb;
  import xcfr_pkg::*;

  // Generous limit for roughly 1.1k items in total, each with random source gaps
  // and sink stalls.
  localparam int unsigned CycleLimit = 40_000;

  // Deframer predictor plus the queue of events it still expects to see
  class frame_event_board;
    cfg_t        cfg;
    phase_e      phase;
    logic [7:0]  cur_id;
    logic [15:0] ann_len;
    logic [15:0] seen_cnt;
    logic [7:0]  xsum;
    logic [15:0] idle_ticks;
    result_t     pending_events[$];
    int unsigned mismatches;
    int unsigned items_taken;
    int unsigned kind_seen[5];

    function new();
      cfg        = '{StartMarkerRst, MaxLenRst, GapTimeoutRst};
      phase      = PH_HUNT;
      cur_id     = '0;
      ann_len    = '0;
      seen_cnt   = '0;
      xsum       = '0;
      idle_ticks = '0;
      mismatches = 0;
      items_taken = 0;
      foreach (kind_seen[k]) kind_seen[k] = 0;
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("[%0t] MISMATCH: %s", $time, msg);
    endfunction

    function string fmt(result_t r);
      return $sformatf("kind %0d id %02h len %0d byte %02h idx %0d", r.event_kind,
                       r.frame_id, r.frame_len, r.payload_byte, r.payload_index);
    endfunction

    // Advance the predicted receiver by one accepted transaction
    function void absorb_rx_item(item_t it);
      result_t    ev;
      bit         hit;
      logic [7:0] b;
      ev  = '0;
      hit = 1'b0;
      b   = it.rx_byte;
      items_taken++;
      if (it.req_type == REQ_TICK) begin
        // ticks only count inside a frame
        if (phase != PH_HUNT) begin
          if (idle_ticks != IdleSat) idle_ticks++;
          if (idle_ticks >= cfg.gap_timeout_ticks) begin
            ev.event_kind = EV_TIMEOUT;
            ev.frame_len  = (phase >= PH_DATA) ? ann_len : 16'd0;
            hit        = 1'b1;
            phase      = PH_HUNT;
            idle_ticks = '0;
          end
        end
      end else begin
        idle_ticks = '0;
        case (phase)
          PH_ID: begin
            cur_id = b;
            xsum   ^= b;
            phase  = PH_LEN_HI;
          end
          PH_LEN_HI: begin
            ann_len = {b, 8'h00};
            xsum    ^= b;
            phase   = PH_LEN_LO;
          end
          PH_LEN_LO: begin
            ann_len = {ann_len[15:8], b};
            xsum    ^= b;
            if (ann_len > cfg.max_payload_len) begin
              ev.event_kind = EV_TOO_LONG;
              ev.frame_len  = ann_len;
              hit        = 1'b1;
              phase      = PH_HUNT;
              idle_ticks = '0;
            end else begin
              phase = (ann_len == 16'd0) ? PH_CHECK : PH_DATA;
            end
          end
          PH_DATA: begin
            ev.event_kind    = EV_DATA;
            ev.frame_len     = ann_len;
            ev.payload_byte  = b;
            ev.payload_index = seen_cnt;
            hit      = 1'b1;
            xsum     ^= b;
            seen_cnt++;
            if (seen_cnt >= ann_len) phase = PH_CHECK;
          end
          PH_CHECK: begin
            ev.event_kind = (b == xsum) ? EV_GOOD : EV_BAD_SUM;
            ev.frame_len  = ann_len;
            hit        = 1'b1;
            phase      = PH_HUNT;
            idle_ticks = '0;
          end
          default: begin
            // hunting: only the start marker opens a frame
            if (b == cfg.start_marker) begin
              phase    = PH_ID;
              xsum     = b;
              cur_id   = '0;
              ann_len  = '0;
              seen_cnt = '0;
            end
          end
        endcase
      end
      if (hit) begin
        ev.frame_id = cur_id;
        pending_events.push_back(ev);
      end
    endfunction

    // Compare one result transaction with the oldest expected event
    function void match_event(result_t got);
      result_t want;
      if (pending_events.size() == 0) begin
        flag({"unexpected event: ", fmt(got)});
        return;
      end
      want = pending_events.pop_front();
      kind_seen[want.event_kind]++;
      if (got.event_kind !== want.event_kind || got.frame_id !== want.frame_id ||
          got.frame_len !== want.frame_len || got.payload_byte !== want.payload_byte ||
          got.payload_index !== want.payload_index)
        flag({"expected ", fmt(want), ", got ", fmt(got)});
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  xcfr_in_if  in_bus ();
  xcfr_out_if out_bus ();

  frame_event_board sb = new();

  logic [7:0]  wire_bytes[$];
  int unsigned frame_items = 0;
  int unsigned cycle_count = 0;
  int unsigned cfg_changes = 0;
  bit          quiet = 1'b0;

  xor_checked_frame_receiver u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (in_bus),
    .out_if  (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result sink: check every accepted event, stall at random
  initial begin
    result_t seen_ev;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_bus.valid && out_bus.ready) begin
        seen_ev.event_kind    = out_bus.event_kind;
        seen_ev.frame_id      = out_bus.frame_id;
        seen_ev.frame_len     = out_bus.frame_len;
        seen_ev.payload_byte  = out_bus.payload_byte;
        seen_ev.payload_index = out_bus.payload_index;
        sb.match_event(seen_ev);
      end
      out_bus.ready <= quiet || ($urandom_range(0, 99) >= 17);
    end
  end

  // One input transaction, with a random lead-in gap
  task automatic send_item(input req_e kind, input logic [7:0] b);
    item_t it;
    it.req_type = kind;
    it.rx_byte  = b;
    while (!quiet && $urandom_range(0, 99) < 17) begin
      in_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_bus.valid    <= 1'b1;
    in_bus.req_type <= kind;
    in_bus.rx_byte  <= b;
    do @(posedge clk_i); while (!in_bus.ready);
    sb.absorb_rx_item(it);
  endtask

  // Hold input off until all expected events are out, then let the pipe empty
  task automatic settle();
    in_bus.valid <= 1'b0;
    while (sb.pending_events.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // APB write followed by a read back of the same register
  task automatic write_reg(input reg_idx_e idx, input logic [15:0] value);
    logic [31:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ApbAddrW'({idx, 2'b00});
    pwdata  <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== 32'(value))
      sb.flag($sformatf("register %0d reads %h, wrote %h", idx, rd, value));
    case (idx)
      REG_START_MARKER: sb.cfg.start_marker      = value[7:0];
      REG_MAX_LEN:      sb.cfg.max_payload_len   = value;
      REG_GAP_TIMEOUT:  sb.cfg.gap_timeout_ticks = value;
      default: ;
    endcase
  endtask

  task automatic apply_cfg(input logic [7:0] mk, input logic [15:0] lim,
                           input logic [15:0] gap);
    settle();
    write_reg(REG_START_MARKER, {8'h00, mk});
    write_reg(REG_MAX_LEN, lim);
    write_reg(REG_GAP_TIMEOUT, gap);
    cfg_changes++;
  endtask

  // Close the frame in wire_bytes with its checksum, optionally corrupted
  task automatic append_sum(input bit bad);
    logic [7:0] s;
    s = '0;
    foreach (wire_bytes[i]) s ^= wire_bytes[i];
    if (bad) s ^= 8'(1 << $urandom_range(0, 7));
    wire_bytes.push_back(s);
  endtask

  // Send wire_bytes with idle ticks between bytes; a cut >= 0 stops after that
  // many bytes and then lets the gap timer run out
  task automatic play_frame(input int cut);
    int n;
    int gap;
    gap = int'(sb.cfg.gap_timeout_ticks);
    n   = (cut < 0) ? wire_bytes.size() : cut;
    for (int i = 0; i < n; i++) begin
      send_item(REQ_BYTE, wire_bytes[i]);
      frame_items++;
      if (i < n - 1 && gap > 1 && $urandom_range(0, 99) < 12) begin
        repeat ($urandom_range(1, (gap - 1 < 40) ? gap - 1 : 40)) begin
          send_item(REQ_TICK, 8'($urandom));
          frame_items++;
        end
      end
    end
    if (cut >= 0) begin
      repeat ((gap == 0) ? 1 : gap) begin
        send_item(REQ_TICK, 8'($urandom));
        frame_items++;
      end
    end
  endtask

  // Mostly well-formed frames; some line noise, bad sums, long lengths, cut frames
  task automatic random_frame();
    logic [7:0]  mk;
    logic [7:0]  b;
    logic [15:0] len;
    logic [15:0] lim;
    int          cut;
    mk  = sb.cfg.start_marker;
    lim = sb.cfg.max_payload_len;
    if ($urandom_range(0, 99) < 15) begin
      b = 8'($urandom);
      if (b == mk) b = ~b;
      send_item(REQ_BYTE, b);
    end
    if ($urandom_range(0, 99) < 10) send_item(REQ_TICK, 8'($urandom));
    if (lim != 16'hFFFF && $urandom_range(0, 99) < 8)
      len = (lim > 16'hFEFF) ? 16'hFFFF : lim + 16'd1 + 16'($urandom_range(0, 255));
    else
      len = 16'($urandom_range(0, (lim < 16'd24) ? int'(lim) : 24));
    wire_bytes = '{mk, 8'($urandom), len[15:8], len[7:0]};
    if (len <= lim) begin
      repeat (len) wire_bytes.push_back(8'($urandom));
      append_sum($urandom_range(0, 99) < 20);
    end
    cut = -1;
    if (sb.cfg.gap_timeout_ticks <= 16'd200 && $urandom_range(0, 99) < 7)
      cut = $urandom_range(1, wire_bytes.size() - 1);
    play_frame(cut);
  endtask

  task automatic random_round(input int unsigned n_items);
    int unsigned start;
    start = frame_items;
    while (frame_items - start < n_items) begin
      random_frame();
      if ($urandom_range(0, 99) < 3) settle();
    end
  endtask

  // Main sequence
  initial begin
    rst_ni          <= 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    in_bus.valid    <= 1'b0;
    in_bus.req_type <= 1'b0;
    in_bus.rx_byte  <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: noise and a tick while hunting
    send_item(REQ_BYTE, 8'h00);
    send_item(REQ_TICK, 8'hFF);
    // good frame with extreme bytes and the start marker inside the payload
    wire_bytes = '{8'hAA, 8'hFF, 8'h00, 8'h03, 8'h00, 8'hFF, 8'hAA};
    append_sum(1'b0);
    play_frame(-1);
    // zero length, good and bad checksum
    wire_bytes = '{8'hAA, 8'h00, 8'h00, 8'h00};
    append_sum(1'b0);
    play_frame(-1);
    wire_bytes = '{8'hAA, 8'h5A, 8'h00, 8'h00};
    append_sum(1'b1);
    play_frame(-1);
    // lengths over the limit
    wire_bytes = '{8'hAA, 8'h01, 8'h01, 8'h01};
    play_frame(-1);
    wire_bytes = '{8'hAA, 8'h02, 8'hFF, 8'hFF};
    play_frame(-1);
    random_round(180);

    // Low extremes: marker 0, no payload allowed, zero timeout
    apply_cfg(8'h00, 16'd0, 16'd0);
    wire_bytes = '{8'h00};
    play_frame(1);
    wire_bytes = '{8'h00, 8'h12, 8'h00};
    play_frame(3);
    wire_bytes = '{8'h00, 8'h34, 8'h00, 8'h00};
    append_sum(1'b0);
    play_frame(-1);
    wire_bytes = '{8'h00, 8'h56, 8'h00, 8'h01};
    play_frame(-1);
    random_round(120);

    // High extremes: widest marker, limit and gap settings
    apply_cfg(8'hFF, 16'hFFFF, 16'hFFFF);
    quiet = 1'b1;
    wire_bytes = '{8'hFF, 8'h80, 8'h00, 8'h02, 8'h11, 8'h22};
    append_sum(1'b0);
    play_frame(-1);
    random_round(150);
    quiet = 1'b0;

    // Random settings, one round without any idling
    for (int r = 0; r < 4; r++) begin
      apply_cfg(8'($urandom), 16'($urandom_range(0, 40)), 16'($urandom_range(1, 40)));
      quiet = (r == 2);
      random_round(160);
    end
    quiet = 1'b0;

    settle();
    $display("Covered %0d input transactions over %0d register settings after reset.",
             sb.items_taken, cfg_changes);
    $display("Events: data %0d, good %0d, bad sum %0d, too long %0d, timeout %0d.",
             sb.kind_seen[EV_DATA], sb.kind_seen[EV_GOOD], sb.kind_seen[EV_BAD_SUM],
             sb.kind_seen[EV_TOO_LONG], sb.kind_seen[EV_TIMEOUT]);
    if (sb.mismatches == 0 && sb.pending_events.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
